// ===== design/srgbeg_pkg.sv =====
// Shared constants, types and elaboration-time table builders for the sRGB exposure gain unit.
// Depends on nothing; every other design file imports it.
package srgbeg_pkg;

  localparam int LINEAR_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_W         = 16;
  localparam int BYTE_W         = 8;
  localparam int WORK_BITS      = 30;
  // Linear value including the 1.0 code
  localparam int LIN_W          = LINEAR_BITS + 1;
  localparam int PROD_W         = LIN_W + GAIN_W;
  localparam int DEC_DEPTH      = 256;
  localparam int THR_DEPTH      = 255;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [LIN_W-1:0]  LIN_ONE    = LIN_W'(1) << LINEAR_BITS;

  typedef logic [LIN_W-1:0] dec_tab_t [DEC_DEPTH];
  typedef logic [LIN_W-1:0] thr_tab_t [THR_DEPTH];

  // Restoring long division, used only while building constant tables
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> WORK_BITS;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int i = 0; i < 4; i++) p = qmul(p, r);
    return p;
  endfunction

  // Largest Q30 value whose fifth power stays at or below x
  function automatic logic [63:0] root5(input logic [63:0] x);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = 64'(1) << WORK_BITS;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5(mid) <= x) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // Linear light of sRGB code n/d in Q(LINEAR_BITS)
  function automatic logic [LIN_W-1:0] decode_frac(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] lin;
    logic [63:0] den;
    logic [63:0] base;
    logic [63:0] b2;
    if (64'd100000 * n <= 64'd4045 * d) begin
      den = 64'd1292 * d;
      lin = udiv(((64'd100 * n) << WORK_BITS) + (den >> 1), den);
    end else begin
      den  = 64'd1055 * d;
      base = udiv(((64'd1000 * n + 64'd55 * d) << WORK_BITS) + (den >> 1), den);
      if (base > (64'(1) << WORK_BITS)) base = 64'(1) << WORK_BITS;
      b2  = qmul(base, base);
      lin = qmul(b2, root5(b2));
    end
    if (LINEAR_BITS >= WORK_BITS) begin
      lin = lin << (LINEAR_BITS - WORK_BITS);
    end else begin
      lin = (lin + (64'(1) << (WORK_BITS - LINEAR_BITS - 1))) >> (WORK_BITS - LINEAR_BITS);
    end
    return lin[LIN_W-1:0];
  endfunction

  function automatic dec_tab_t build_decode();
    dec_tab_t t;
    for (int k = 0; k < DEC_DEPTH; k++) t[k] = decode_frac(64'(k), 64'd255);
    return t;
  endfunction

  function automatic thr_tab_t build_thresh();
    thr_tab_t t;
    for (int k = 0; k < THR_DEPTH; k++) t[k] = decode_frac(64'(2 * k + 1), 64'd510);
    return t;
  endfunction

  localparam dec_tab_t DECODE_TAB = build_decode();
  localparam thr_tab_t THRESH_TAB = build_thresh();

endpackage

// ===== design/srgbeg_scale.sv =====
// Decode one sRGB byte to linear light and multiply by the gain; registered product.
// Depends on srgbeg_pkg.
module srgbeg_scale import srgbeg_pkg::*; (
  input  logic              clk,
  input  logic [BYTE_W-1:0] code,
  input  logic [GAIN_W-1:0] gain,
  output logic [PROD_W-1:0] prod
);

  logic [LIN_W-1:0] lin;

  // Look up linear light
  assign lin = DECODE_TAB[code];

  // Register the product
  always_ff @(posedge clk) begin
    prod <= PROD_W'(lin) * PROD_W'(gain);
  end

endmodule

// ===== design/srgbeg_encode.sv =====
// Round and clamp the scaled linear value, then re-encode it to an sRGB byte by comparing
// it with all midpoint thresholds at once; registered byte. Depends on srgbeg_pkg.
module srgbeg_encode import srgbeg_pkg::*; (
  input  logic              clk,
  input  logic [PROD_W-1:0] prod,
  output logic [BYTE_W-1:0] code
);

  logic [PROD_W:0]       rnd;
  logic [LIN_W-1:0]      lin;
  logic [THR_DEPTH-1:0]  hit;
  logic [BYTE_W-1:0]     cnt;
  logic [BYTE_W-1:0]     cand;

  // Drop gain fraction with round half up, clamp to 1.0
  assign rnd = ({1'b0, prod} + (PROD_W+1)'(1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
  assign lin = (rnd > (PROD_W+1)'(LIN_ONE)) ? LIN_ONE : rnd[LIN_W-1:0];

  // Compare against every threshold in parallel
  always_comb begin
    for (int k = 0; k < THR_DEPTH; k++) begin
      hit[k] = (lin >= THRESH_TAB[k]);
    end
  end

  // Thresholds rise monotonically, so hit is a thermometer code; find its length
  always_comb begin
    cnt  = '0;
    cand = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      cand = cnt | BYTE_W'(1 << b);
      if (hit[cand - BYTE_W'(1)]) cnt = cand;
    end
  end

  always_ff @(posedge clk) begin
    code <= cnt;
  end

endmodule

// ===== design/srgb_exposure_gain_unit.sv =====
// Top level of the sRGB exposure gain unit: gain register, input register, three color
// lanes and the result strobe. Depends on srgbeg_pkg, srgbeg_scale, srgbeg_encode.
//
// Usage:
//   Input channel: drive red_in, green_in, blue_in, alpha_in with start high; the pixel
//   transfers at a rising edge where start is high and busy is low. busy is always low,
//   so one pixel transfers every cycle.
//   Result channel: done is high for exactly one cycle with red_out, green_out,
//   blue_out and alpha_out; the receiver takes it at the edge ending that cycle and
//   cannot stall it.
//   Pipeline: the input register, product register and result register lie between
//   the start edge and the done cycle. Throughput: 1 pixel/cycle, set by one 25x16
//   multiply per lane in the product stage.
//   Configuration: cfg_we with cfg_wdata writes the Q4.12 gain; write only when no
//   pixel is in flight.
//   Reset (rst, synchronous): clears the pipeline valids, so done stays low, and sets
//   the gain to unity (4096).
module srgb_exposure_gain_unit import srgbeg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] red_in,
  input  logic [BYTE_W-1:0] green_in,
  input  logic [BYTE_W-1:0] blue_in,
  input  logic [BYTE_W-1:0] alpha_in,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata,
  output logic              done,
  output logic [BYTE_W-1:0] red_out,
  output logic [BYTE_W-1:0] green_out,
  output logic [BYTE_W-1:0] blue_out,
  output logic [BYTE_W-1:0] alpha_out
);

  logic [GAIN_W-1:0] gain;
  logic [2:0]        vld;
  logic [BYTE_W-1:0] pix [3];
  logic [BYTE_W-1:0] alpha_s0;
  logic [BYTE_W-1:0] alpha_s1;
  logic [PROD_W-1:0] prod [3];
  logic [BYTE_W-1:0] res [3];

  assign busy = 1'b0;

  // Hold the gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  // Advance the valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start & ~busy};
    end
  end

  // Capture the pixel and carry alpha alongside
  always_ff @(posedge clk) begin
    pix[0]    <= red_in;
    pix[1]    <= green_in;
    pix[2]    <= blue_in;
    alpha_s0  <= alpha_in;
    alpha_s1  <= alpha_s0;
    alpha_out <= alpha_s1;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    srgbeg_scale u_scale (
      .clk  (clk),
      .code (pix[i]),
      .gain (gain),
      .prod (prod[i])
    );
    srgbeg_encode u_encode (
      .clk  (clk),
      .prod (prod[i]),
      .code (res[i])
    );
  end

  assign red_out   = res[0];
  assign green_out = res[1];
  assign blue_out  = res[2];
  assign done      = vld[2];

endmodule

// ===== design/srgbeg_checker.sv =====
// Port-level checks for the sRGB exposure gain unit, bound to the top level.
// Depends on srgbeg_pkg and srgb_exposure_gain_unit.
module srgbeg_checker import srgbeg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [BYTE_W-1:0] alpha_in,
  input logic              done,
  input logic [BYTE_W-1:0] alpha_out
);

  // Every result comes from an input transfer carried down the valid pipeline
  a_done_has_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3) && !$past(busy, 3))
    else $error("result without a matching input transfer");

  // Every transfer that no reset interrupts while in flight yields a result
  a_src_has_done: assert property (@(posedge clk) disable iff (rst)
    ($past(start, 3) && !$past(busy, 3) && !$past(rst, 1) && !$past(rst, 2)
     && !$past(rst, 3)) |-> done)
    else $error("input transfer lost");

  // Alpha travels with its pixel
  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> alpha_out == $past(alpha_in, 3))
    else $error("alpha changed in flight");

endmodule

bind srgb_exposure_gain_unit srgbeg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .alpha_in  (alpha_in),
  .done      (done),
  .alpha_out (alpha_out)
);

// ===== tb/tb_srgb_exposure_gain_unit.sv =====
// Self-checking testbench for the sRGB exposure gain unit: drives pixels and gain writes,
// predicts each result from its own fixed-point tables. Depends on srgbeg_pkg and the unit.
`timescale 1ns / 100ps
module tb_srgb_exposure_gain_unit;
  import srgbeg_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } pixel_t;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [BYTE_W-1:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic cfg_we = 1'b0;
  logic [GAIN_W-1:0] cfg_wdata = '0;
  logic done;
  logic [BYTE_W-1:0] red_out, green_out, blue_out, alpha_out;

  longint unsigned lin_of_code [256];
  longint unsigned mid_thresh [255];
  logic [GAIN_W-1:0] gain_shadow;
  pixel_t pending_pixels [$];
  int error_count = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  srgb_exposure_gain_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .alpha_out(alpha_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Q30 fixed-point helpers for the gamma tables
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = q30_mul(p, r);
    return p;
  endfunction

  // Convert sRGB code n/d to linear light in Q24
  function automatic longint unsigned srgb_to_linear(longint unsigned n, longint unsigned d);
    longint unsigned den, acc, sq, lo, hi, mid;
    if (100000 * n <= 4045 * d) begin
      den = 1292 * d;
      acc = (((100 * n) << 30) + den / 2) / den;
    end else begin
      den = 1055 * d;
      acc = (((1000 * n + 55 * d) << 30) + den / 2) / den;
      if (acc > Q30_ONE) acc = Q30_ONE;
      sq = q30_mul(acc, acc);
      lo = 0;
      hi = Q30_ONE;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (fifth_power(mid) <= sq) lo = mid;
        else hi = mid - 1;
      end
      acc = q30_mul(sq, lo);
    end
    return (acc + (64'd1 << (29 - LINEAR_BITS))) >> (30 - LINEAR_BITS);
  endfunction

  // Apply gain, clamp to 1.0 and re-encode by threshold count
  function automatic logic [BYTE_W-1:0] exposed_byte(logic [BYTE_W-1:0] code);
    longint unsigned v;
    int cnt;
    v = (lin_of_code[code] * gain_shadow + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
    if (v > (64'd1 << LINEAR_BITS)) v = 64'd1 << LINEAR_BITS;
    cnt = 0;
    for (int k = 0; k < 255; k++) if (v >= mid_thresh[k]) cnt++;
    return cnt[BYTE_W-1:0];
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Check each result strobe against the oldest predicted pixel
  always @(posedge clk) begin
    pixel_t want;
    if (done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
        if (green_out !== want.green) report_mismatch("green_out", green_out, want.green);
        if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
        if (alpha_out !== want.alpha) report_mismatch("alpha_out", alpha_out, want.alpha);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("tb_srgb_exposure_gain_unit NOT OK");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pixel_t want;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    alpha_in <= a;
    do @(posedge clk); while (busy);
    want.red = exposed_byte(r);
    want.green = exposed_byte(g);
    want.blue = exposed_byte(b);
    want.alpha = a;
    pending_pixels = {pending_pixels, want};
  endtask

  // Hold off until the pipeline is empty, then write the gain
  task automatic write_gain(logic [GAIN_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    gain_shadow = value;
  endtask

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd10, 8'd11, 8'd128, 8'd170);
    send_pixel(8'd85, 8'd1, 8'd254, 8'd85);
  endtask

  task automatic test_gain_sweep();
    logic [GAIN_W-1:0] gains [6] = '{16'd0, 16'd65535, 16'd1, 16'd2048, 16'd8192, 16'd4096};
    foreach (gains[i]) begin
      write_gain(gains[i]);
      send_pixel(8'd0, 8'd255, 8'd128, 8'(i));
      send_pixel(8'd10, 8'd11, 8'd200, 8'd255);
    end
  endtask

  task automatic test_random_stream(int pct, int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(3))
          0: write_gain(16'(1 << GAIN_FRAC_BITS));
          1: write_gain(16'($urandom_range(8192)));
          2: write_gain(16'($urandom_range(65535)));
          default: write_gain(16'($urandom_range(4096, 2048)));
        endcase
      end
      if (i == count / 2) begin
        // let every outstanding result arrive before going on
        @(negedge clk);
        start <= 1'b0;
        wait (pending_pixels.size() == 0);
      end
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    for (int k = 0; k < 256; k++) lin_of_code[k] = srgb_to_linear(k, 255);
    for (int k = 0; k < 255; k++) mid_thresh[k] = srgb_to_linear(2 * k + 1, 510);
    gain_shadow = GAIN_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_gain_sweep();
    test_random_stream(18, 190);
    test_random_stream(88, 170);
    test_random_stream(0, 190);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("tb_srgb_exposure_gain_unit OK");
    else $display("tb_srgb_exposure_gain_unit NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
design/srgbeg_pkg.sv
design/srgbeg_scale.sv
design/srgbeg_encode.sv
design/srgb_exposure_gain_unit.sv
design/srgbeg_checker.sv
tb/tb_srgb_exposure_gain_unit.sv
